>>> hdl/assert_macros.svh
// Assertion macros shared by the pixel colour filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while reset is released.
`define PCF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that a condition never holds on a rising edge of clk.
`define PCF_ASSERT_NEVER(label, expr, msg) \
    `PCF_ASSERT(label, !(expr), msg)

`endif

>>> hdl/pcf_pkg.sv
// Types and constants of the pixel colour filter.
package pcf_pkg;

    localparam int PIXEL_W = 32;
    localparam int CHAN_W  = 8;
    localparam int MODE_W  = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE      = 3'd0,
        MODE_GREY      = 3'd1,
        MODE_SEPIA     = 3'd2,
        MODE_POSTERIZE = 3'd3,
        MODE_NEGATE    = 3'd4
    } filter_mode_t;

    // Sepia matrix in unsigned Q10.
    localparam int COEF_W = 10;
    localparam logic [COEF_W-1:0] SEPIA_RR = 10'd402;
    localparam logic [COEF_W-1:0] SEPIA_RG = 10'd787;
    localparam logic [COEF_W-1:0] SEPIA_RB = 10'd194;
    localparam logic [COEF_W-1:0] SEPIA_GR = 10'd357;
    localparam logic [COEF_W-1:0] SEPIA_GG = 10'd702;
    localparam logic [COEF_W-1:0] SEPIA_GB = 10'd172;
    localparam logic [COEF_W-1:0] SEPIA_BR = 10'd279;
    localparam logic [COEF_W-1:0] SEPIA_BG = 10'd547;
    localparam logic [COEF_W-1:0] SEPIA_BB = 10'd134;
    localparam int SEPIA_SHIFT = 10;
    localparam int SEPIA_SUM_W = 19;

    // Division by three as a multiply by 683 and a right shift by 11,
    // exact for every sum of three channels.
    localparam int GREY_SUM_W = 10;
    localparam logic [GREY_SUM_W-1:0] GREY_RECIP = 10'd683;
    localparam int GREY_SHIFT = 11;
    localparam int GREY_PROD_W = 2 * GREY_SUM_W;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE  = 8'hFF;
    localparam logic [CHAN_W-1:0] POSTER_MASK   = 8'hE0;
    localparam logic [CHAN_W-1:0] CHAN_MAX      = 8'hFF;

endpackage

>>> hdl/pcf_in_if.sv
// Input channel of the pixel colour filter: one pixel item per handshake.
interface pcf_in_if
    import pcf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_in;
    logic               last_in;

    modport source (output valid, output pixel_in, output last_in, input ready);
    modport sink (input valid, input pixel_in, input last_in, output ready);
endinterface

>>> hdl/pcf_out_if.sv
// Output channel of the pixel colour filter: one filtered pixel item per handshake.
interface pcf_out_if
    import pcf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_out;
    logic               last_out;

    modport source (output valid, output pixel_out, output last_out, input ready);
    modport sink (input valid, input pixel_out, input last_out, output ready);
endinterface

>>> hdl/pcf_datapath.sv
// Combinational filter datapath: grey, sepia, posterize, negate or pass-through of one pixel.
module pcf_datapath
    import pcf_pkg::*;
(
    input  filter_mode_t        mode,
    input  logic [PIXEL_W-1:0]  pixel,
    output logic [PIXEL_W-1:0]  result
);

    logic [CHAN_W-1:0]      red;
    logic [CHAN_W-1:0]      green;
    logic [CHAN_W-1:0]      blue;
    logic [GREY_SUM_W-1:0]  grey_sum;
    logic [GREY_PROD_W-1:0] grey_prod;
    logic [CHAN_W-1:0]      grey;
    logic [SEPIA_SUM_W-1:0] sepia_r_sum;
    logic [SEPIA_SUM_W-1:0] sepia_g_sum;
    logic [SEPIA_SUM_W-1:0] sepia_b_sum;
    logic [CHAN_W-1:0]      sepia_r;
    logic [CHAN_W-1:0]      sepia_g;
    logic [CHAN_W-1:0]      sepia_b;

    function automatic logic [SEPIA_SUM_W-1:0] weigh(
        input logic [COEF_W-1:0] c,
        input logic [CHAN_W-1:0] v
    );
        logic [COEF_W+CHAN_W-1:0] p;
        begin
            p = COEF_W'(c) * (COEF_W+CHAN_W)'(v);
            weigh = SEPIA_SUM_W'(p);
        end
    endfunction

    function automatic logic [CHAN_W-1:0] saturate(input logic [SEPIA_SUM_W-1:0] s);
        logic [SEPIA_SUM_W-SEPIA_SHIFT-1:0] q;
        begin
            q = s[SEPIA_SUM_W-1:SEPIA_SHIFT];
            if (q > (SEPIA_SUM_W-SEPIA_SHIFT)'(CHAN_MAX))
            begin
                saturate = CHAN_MAX;
            end
            else
            begin
                saturate = q[CHAN_W-1:0];
            end
        end
    endfunction

    assign red   = pixel[3*CHAN_W-1:2*CHAN_W];
    assign green = pixel[2*CHAN_W-1:CHAN_W];
    assign blue  = pixel[CHAN_W-1:0];

    assign grey_sum  = GREY_SUM_W'(red) + GREY_SUM_W'(green) + GREY_SUM_W'(blue);
    assign grey_prod = GREY_PROD_W'(grey_sum) * GREY_PROD_W'(GREY_RECIP);
    assign grey      = grey_prod[GREY_SHIFT+CHAN_W-1:GREY_SHIFT];

    assign sepia_r_sum = weigh(SEPIA_RR, red) + weigh(SEPIA_RG, green) + weigh(SEPIA_RB, blue);
    assign sepia_g_sum = weigh(SEPIA_GR, red) + weigh(SEPIA_GG, green) + weigh(SEPIA_GB, blue);
    assign sepia_b_sum = weigh(SEPIA_BR, red) + weigh(SEPIA_BG, green) + weigh(SEPIA_BB, blue);
    assign sepia_r     = saturate(sepia_r_sum);
    assign sepia_g     = saturate(sepia_g_sum);
    assign sepia_b     = saturate(sepia_b_sum);

    always_comb
    begin
        case (mode)
            MODE_GREY:
            begin
                result = {ALPHA_OPAQUE, grey, grey, grey};
            end
            MODE_SEPIA:
            begin
                result = {ALPHA_OPAQUE, sepia_r, sepia_g, sepia_b};
            end
            MODE_POSTERIZE:
            begin
                result = {ALPHA_OPAQUE, red & POSTER_MASK, green & POSTER_MASK,
                          blue & POSTER_MASK};
            end
            MODE_NEGATE:
            begin
                result = PIXEL_W'(0) - pixel;
            end
            default:
            begin
                result = pixel;
            end
        endcase
    end

endmodule

>>> hdl/pixel_colour_filter_unit.sv
// Top level of the pixel colour filter: input register, filter datapath, result register.
// The unit takes one ARGB pixel item per clock while pix_in.ready is high and returns the
// filtered pixel once it has passed the input register and then the result register,
// with the whole filter computed in the single logic stage between them. A pixel is
// accepted while an earlier result still waits downstream, as long as one of the two
// registers can move. The filter mode is written through cfg_we and cfg_wdata and should
// only change while no pixel is in flight; mode values 5 to 7 pass pixels through.
`include "assert_macros.svh"

module pixel_colour_filter_unit
    import pcf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [MODE_W-1:0] cfg_wdata,
    pcf_in_if.sink            pix_in,
    pcf_out_if.source         pix_out
);

    filter_mode_t       mode_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic               s1_last_reg;
    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic [PIXEL_W-1:0] s2_pixel_reg;
    logic [PIXEL_W-1:0] s2_pixel_next;
    logic               s2_last_reg;
    logic               in_accept;
    logic               s2_load;

    assign s2_load      = s1_valid_reg && (!s2_valid_reg || pix_out.ready);
    assign pix_in.ready = !s1_valid_reg || s2_load;
    assign in_accept    = pix_in.valid && pix_in.ready;

    pcf_datapath u_datapath (
        .mode   (mode_reg),
        .pixel  (s1_pixel_reg),
        .result (s2_pixel_next)
    );

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s2_load)
        begin
            s2_valid_next = 1'b1;
        end
        else if (pix_out.ready)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NONE;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= filter_mode_t'(cfg_wdata);
            end
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= pix_in.pixel_in;
            s1_last_reg  <= pix_in.last_in;
        end
        if (s2_load)
        begin
            s2_pixel_reg <= s2_pixel_next;
            s2_last_reg  <= s1_last_reg;
        end
    end

    assign pix_out.valid     = s2_valid_reg;
    assign pix_out.pixel_out = s2_pixel_reg;
    assign pix_out.last_out  = s2_last_reg;

    // An accepted pixel always lands in the input register.
    `PCF_ASSERT(a_accept_fills_s1, in_accept |=> s1_valid_reg, "accepted item was lost")

    // A pixel moved into the result register must be presented next cycle.
    `PCF_ASSERT(a_load_fills_s2, s2_load |=> s2_valid_reg, "result item was lost")

    // The input register may not be overwritten while its pixel is still held.
    `PCF_ASSERT_NEVER(a_no_overwrite, in_accept && s1_valid_reg && !s2_load,
        "input item overwritten")

    // Grey, sepia and posterize produce an opaque alpha.
    `PCF_ASSERT(a_opaque_alpha,
        (s2_load && (mode_reg == MODE_GREY || mode_reg == MODE_SEPIA ||
        mode_reg == MODE_POSTERIZE)) |=> (s2_pixel_reg[PIXEL_W-1:PIXEL_W-CHAN_W] == ALPHA_OPAQUE),
        "alpha not forced opaque")

    // Negation is the two's complement of the whole word.
    `PCF_ASSERT(a_negate_word,
        (s2_load && mode_reg == MODE_NEGATE) |=>
        (s2_pixel_reg == (PIXEL_W'(0) - $past(s1_pixel_reg))),
        "negated word mismatch")

endmodule
